[rtl/spa_pkg.sv]
// Shared types and constants of the segment placement allocator.
// Used by every module of the block; depends on nothing.
package spa_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int SIZE_BITS_DEF = 40;
  localparam int SLOT_W = 4;
  localparam int AMT_W = 40;
  localparam int MED_W = 3;
  localparam int LAT_W = 32;
  localparam int RR_W = 32;

  typedef enum logic [1:0] {
    OP_REG     = 2'd0,
    OP_UNREG   = 2'd1,
    OP_ALLOC   = 2'd2,
    OP_DEALLOC = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_BAD_SIZE  = 3'd3,
    ST_NO_SPACE  = 3'd4,
    ST_INTERNAL  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    POL_CAP = 2'd0,
    POL_LAT = 2'd1,
    POL_RR  = 2'd2,
    POL_LOC = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    CH_PREF = 2'd0,
    CH_MED  = 2'd1,
    CH_CAP  = 2'd2,
    CH_LAT  = 2'd3
  } ch_sel_t;

  typedef struct packed {
    logic    load;
    logic    reg_wr;
    logic    unreg;
    logic    rd_slot;
    logic    dealloc_wr;
    logic    scan_clr;
    logic    scan_rd;
    logic    pass2;
    logic    ch_load;
    ch_sel_t ch_sel;
    logic    div_start;
    logic    rr_inc;
    logic    rd_chosen;
    logic    alloc_wr;
    logic    res_load;
    status_t res_code;
    logic    res_alloc;
  } cmd_t;

  typedef struct packed {
    op_t     op;
    logic    in_table;
    logic    slot_valid;
    logic    size_zero;
    logic    used_ge;
    logic    pref_hit;
    logic    med_hit;
    logic    any_ok;
    policy_t policy;
    logic    cap_found;
    logic    lat_found;
    logic    cnt_zero;
    logic    cnt_last;
    logic    div_done;
  } stat_t;

endpackage

[rtl/spa_rr_mod.sv]
// Bit-serial remainder unit for the round robin pick.
// Depends on spa_pkg for the counter width.
module spa_rr_mod #(
  parameter int CNT_W = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [spa_pkg::RR_W-1:0]   dividend,
  input  logic [CNT_W-1:0]           divisor,
  output logic                       done,
  output logic [CNT_W-1:0]           rem
);

  localparam int BW = $clog2(spa_pkg::RR_W);

  logic          run;
  logic [BW-1:0] bit_cnt;
  logic [spa_pkg::RR_W-1:0] shreg;
  logic [CNT_W:0] trial;
  logic [CNT_W:0] dvs;

  assign trial = {rem, shreg[spa_pkg::RR_W-1]};
  assign dvs = {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        bit_cnt <= '0;
        shreg <= dividend;
        rem <= '0;
      end else if (run) begin
        shreg <= shreg << 1;
        rem <= (trial >= dvs) ? CNT_W'(trial - dvs) : CNT_W'(trial);
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_cnt == BW'(spa_pkg::RR_W - 1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/spa_datapath.sv]
// Datapath: slot table memory, valid flags, scan accumulators and result registers.
// Depends on spa_pkg and spa_rr_mod.
module spa_datapath #(
  parameter int NUM_SLOTS = spa_pkg::NUM_SLOTS_DEF,
  parameter int SIZE_BITS = spa_pkg::SIZE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  spa_pkg::cmd_t              cmd,
  output spa_pkg::stat_t             stat,
  input  logic [1:0]                 opcode,
  input  logic [spa_pkg::SLOT_W-1:0] slot,
  input  logic [spa_pkg::AMT_W-1:0]  amount,
  input  logic [spa_pkg::MED_W-1:0]  medium_req,
  input  logic [spa_pkg::LAT_W-1:0]  access_lat,
  input  logic [1:0]                 policy,
  input  logic [spa_pkg::SLOT_W-1:0] pref_slot,
  input  logic                       pref_slot_valid,
  input  logic [spa_pkg::MED_W-1:0]  pref_medium,
  input  logic                       pref_medium_valid,
  input  logic                       any_medium_ok,
  output logic                       done,
  output logic [2:0]                 status,
  output logic [spa_pkg::SLOT_W-1:0] chosen_slot,
  output logic [spa_pkg::AMT_W-1:0]  offset,
  output logic [spa_pkg::MED_W-1:0]  chosen_medium
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  logic [1:0]                 op_q;
  logic [spa_pkg::SLOT_W-1:0] slot_q;
  logic [SIZE_BITS-1:0]       amt_q;
  logic [spa_pkg::MED_W-1:0]  med_q;
  logic [spa_pkg::LAT_W-1:0]  lat_q;
  logic [1:0]                 pol_q;
  logic [spa_pkg::SLOT_W-1:0] pslot_q;
  logic                       pslot_v_q;
  logic [spa_pkg::MED_W-1:0]  pmed_q;
  logic                       pmed_v_q;
  logic                       any_q;

  logic [NUM_SLOTS-1:0]       valid;
  logic [SIZE_BITS-1:0]       mem_cap [NUM_SLOTS];
  logic [SIZE_BITS-1:0]       mem_used [NUM_SLOTS];
  logic [spa_pkg::MED_W-1:0]  mem_med [NUM_SLOTS];
  logic [spa_pkg::LAT_W-1:0]  mem_lat [NUM_SLOTS];

  logic [SIZE_BITS-1:0]       rd_cap;
  logic [SIZE_BITS-1:0]       rd_used;
  logic [spa_pkg::MED_W-1:0]  rd_med;
  logic [spa_pkg::LAT_W-1:0]  rd_lat;
  logic [IDX_W-1:0]           rd_idx;
  logic                       scan_act;
  logic                       scan_p2;

  logic [IDX_W-1:0]           cnt;
  logic [IDX_W-1:0]           raddr;
  logic                       rd_en;
  logic [IDX_W-1:0]           slot_idx;
  logic                       in_table;
  logic [SIZE_BITS-1:0]       free_sp;
  logic                       fit;

  logic                       pref_hit;
  logic                       med_hit;
  logic [IDX_W-1:0]           med_idx;
  logic [CNT_W-1:0]           fit_cnt;
  logic                       cap_found;
  logic [IDX_W-1:0]           cap_idx;
  logic [SIZE_BITS-1:0]       max_free;
  logic                       lat_found;
  logic [IDX_W-1:0]           lat_idx;
  logic [spa_pkg::LAT_W-1:0]  min_lat;
  logic [CNT_W-1:0]           k;
  logic                       rr_found;
  logic [CNT_W-1:0]           pick;
  logic                       div_done;
  logic [IDX_W-1:0]           chosen;
  logic [spa_pkg::RR_W-1:0]   rr;

  assign slot_idx = IDX_W'(slot_q);
  assign in_table = 32'(slot_q) < NUM_SLOTS;
  assign free_sp = (rd_used > rd_cap) ? '0 : rd_cap - rd_used;
  assign fit = valid[rd_idx] && (free_sp >= amt_q);
  assign rd_en = cmd.rd_slot | cmd.scan_rd | cmd.rd_chosen;

  always_comb begin
    raddr = cnt;
    if (cmd.rd_slot) begin
      raddr = slot_idx;
    end else if (cmd.rd_chosen) begin
      raddr = chosen;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= opcode;
      slot_q <= slot;
      amt_q <= SIZE_BITS'(amount);
      med_q <= medium_req;
      lat_q <= access_lat;
      pol_q <= policy;
      pslot_q <= pref_slot;
      pslot_v_q <= pref_slot_valid;
      pmed_q <= pref_medium;
      pmed_v_q <= pref_medium_valid;
      any_q <= any_medium_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.reg_wr) begin
      valid[slot_idx] <= 1'b1;
    end else if (cmd.unreg) begin
      valid[slot_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reg_wr) begin
      mem_cap[slot_idx] <= amt_q;
      mem_used[slot_idx] <= '0;
      mem_med[slot_idx] <= med_q;
      mem_lat[slot_idx] <= lat_q;
    end else if (cmd.dealloc_wr) begin
      mem_used[slot_idx] <= rd_used - amt_q;
    end else if (cmd.alloc_wr) begin
      mem_used[chosen] <= rd_used + amt_q;
    end
    if (rd_en) begin
      rd_cap <= mem_cap[raddr];
      rd_used <= mem_used[raddr];
      rd_med <= mem_med[raddr];
      rd_lat <= mem_lat[raddr];
    end
    rd_idx <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_act <= 1'b0;
      scan_p2 <= 1'b0;
    end else begin
      scan_act <= cmd.scan_rd;
      scan_p2 <= cmd.pass2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      cnt <= '0;
      k <= '0;
      rr_found <= 1'b0;
      if (!cmd.pass2) begin
        pref_hit <= 1'b0;
        med_hit <= 1'b0;
        fit_cnt <= '0;
        cap_found <= 1'b0;
        lat_found <= 1'b0;
      end
    end else if (cmd.scan_rd) begin
      cnt <= cnt + 1'b1;
    end
    if (cmd.ch_load) begin
      case (cmd.ch_sel)
        spa_pkg::CH_PREF: chosen <= IDX_W'(pslot_q);
        spa_pkg::CH_MED:  chosen <= med_idx;
        spa_pkg::CH_CAP:  chosen <= cap_idx;
        spa_pkg::CH_LAT:  chosen <= lat_idx;
        default:          chosen <= cap_idx;
      endcase
    end
    if (scan_act && fit) begin
      if (!scan_p2) begin
        if (pslot_v_q && (32'(rd_idx) == 32'(pslot_q))) begin
          pref_hit <= 1'b1;
        end
        if (pmed_v_q && !med_hit && (rd_med == pmed_q)) begin
          med_hit <= 1'b1;
          med_idx <= rd_idx;
        end
        fit_cnt <= fit_cnt + 1'b1;
        if (!cap_found || (free_sp > max_free)) begin
          cap_found <= 1'b1;
          cap_idx <= rd_idx;
          max_free <= free_sp;
        end
        if (!lat_found || (rd_lat < min_lat)) begin
          lat_found <= 1'b1;
          lat_idx <= rd_idx;
          min_lat <= rd_lat;
        end
      end else if (!rr_found) begin
        if (k == pick) begin
          rr_found <= 1'b1;
          chosen <= rd_idx;
        end
        k <= k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rr <= '0;
    end else if (cmd.rr_inc) begin
      rr <= rr + 1'b1;
    end
  end

  spa_rr_mod #(
    .CNT_W(CNT_W)
  ) u_rr_mod (
    .clk(clk),
    .rst(rst),
    .start(cmd.div_start),
    .dividend(rr),
    .divisor(fit_cnt),
    .done(div_done),
    .rem(pick)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status <= cmd.res_code;
      if (cmd.res_alloc) begin
        chosen_slot <= spa_pkg::SLOT_W'(chosen);
        offset <= spa_pkg::AMT_W'(rd_used);
        chosen_medium <= rd_med;
      end else begin
        chosen_slot <= '0;
        offset <= '0;
        chosen_medium <= '0;
      end
    end
  end

  always_comb begin
    stat.op = spa_pkg::op_t'(op_q);
    stat.in_table = in_table;
    stat.slot_valid = in_table && valid[slot_idx];
    stat.size_zero = (amt_q == '0);
    stat.used_ge = (rd_used >= amt_q);
    stat.pref_hit = pref_hit;
    stat.med_hit = med_hit;
    stat.any_ok = any_q;
    stat.policy = spa_pkg::policy_t'(pol_q);
    stat.cap_found = cap_found;
    stat.lat_found = lat_found;
    stat.cnt_zero = (fit_cnt == '0);
    stat.cnt_last = (cnt == IDX_W'(NUM_SLOTS - 1));
    stat.div_done = div_done;
  end

endmodule

[rtl/spa_ctrl.sv]
// Controller state machine that sequences each transaction through the datapath.
// Depends on spa_pkg for the command and status structs.
module spa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  spa_pkg::stat_t stat,
  output spa_pkg::cmd_t  cmd,
  output logic           busy
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b00000000001,
    S_DISPATCH  = 11'b00000000010,
    S_DEAL_WAIT = 11'b00000000100,
    S_SCAN      = 11'b00000001000,
    S_DRAIN     = 11'b00000010000,
    S_DECIDE    = 11'b00000100000,
    S_DIV       = 11'b00001000000,
    S_SCAN2     = 11'b00010000000,
    S_DRAIN2    = 11'b00100000000,
    S_FETCH     = 11'b01000000000,
    S_ALLOC_WR  = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          spa_pkg::OP_REG: begin
            cmd.res_load = 1'b1;
            state_next = S_IDLE;
            if (!stat.in_table) begin
              cmd.res_code = spa_pkg::ST_NOT_FOUND;
            end else if (stat.slot_valid) begin
              cmd.res_code = spa_pkg::ST_EXISTS;
            end else begin
              cmd.reg_wr = 1'b1;
              cmd.res_code = spa_pkg::ST_OK;
            end
          end
          spa_pkg::OP_UNREG: begin
            cmd.res_load = 1'b1;
            state_next = S_IDLE;
            if (!stat.slot_valid) begin
              cmd.res_code = spa_pkg::ST_NOT_FOUND;
            end else begin
              cmd.unreg = 1'b1;
              cmd.res_code = spa_pkg::ST_OK;
            end
          end
          spa_pkg::OP_DEALLOC: begin
            if (!stat.slot_valid) begin
              cmd.res_load = 1'b1;
              cmd.res_code = spa_pkg::ST_NOT_FOUND;
              state_next = S_IDLE;
            end else begin
              cmd.rd_slot = 1'b1;
              state_next = S_DEAL_WAIT;
            end
          end
          default: begin
            if (stat.size_zero) begin
              cmd.res_load = 1'b1;
              cmd.res_code = spa_pkg::ST_BAD_SIZE;
              state_next = S_IDLE;
            end else begin
              cmd.scan_clr = 1'b1;
              state_next = S_SCAN;
            end
          end
        endcase
      end
      S_DEAL_WAIT: begin
        cmd.res_load = 1'b1;
        state_next = S_IDLE;
        if (stat.used_ge) begin
          cmd.dealloc_wr = 1'b1;
          cmd.res_code = spa_pkg::ST_OK;
        end else begin
          cmd.res_code = spa_pkg::ST_INTERNAL;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.cnt_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.pref_hit) begin
          cmd.ch_load = 1'b1;
          cmd.ch_sel = spa_pkg::CH_PREF;
          state_next = S_FETCH;
        end else if (stat.med_hit) begin
          cmd.ch_load = 1'b1;
          cmd.ch_sel = spa_pkg::CH_MED;
          state_next = S_FETCH;
        end else if (!stat.any_ok) begin
          cmd.res_load = 1'b1;
          cmd.res_code = spa_pkg::ST_NOT_FOUND;
          state_next = S_IDLE;
        end else if (stat.policy == spa_pkg::POL_RR) begin
          if (stat.cnt_zero) begin
            cmd.res_load = 1'b1;
            cmd.res_code = spa_pkg::ST_NO_SPACE;
            state_next = S_IDLE;
          end else begin
            cmd.div_start = 1'b1;
            state_next = S_DIV;
          end
        end else if (stat.policy == spa_pkg::POL_LAT) begin
          if (stat.lat_found) begin
            cmd.ch_load = 1'b1;
            cmd.ch_sel = spa_pkg::CH_LAT;
            state_next = S_FETCH;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_code = spa_pkg::ST_NO_SPACE;
            state_next = S_IDLE;
          end
        end else begin
          if (stat.cap_found) begin
            cmd.ch_load = 1'b1;
            cmd.ch_sel = spa_pkg::CH_CAP;
            state_next = S_FETCH;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_code = spa_pkg::ST_NO_SPACE;
            state_next = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.scan_clr = 1'b1;
          cmd.pass2 = 1'b1;
          cmd.rr_inc = 1'b1;
          state_next = S_SCAN2;
        end
      end
      S_SCAN2: begin
        cmd.scan_rd = 1'b1;
        cmd.pass2 = 1'b1;
        if (stat.cnt_last) begin
          state_next = S_DRAIN2;
        end
      end
      S_DRAIN2: begin
        state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.rd_chosen = 1'b1;
        state_next = S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        cmd.alloc_wr = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_alloc = 1'b1;
        cmd.res_code = spa_pkg::ST_OK;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/segment_placement_allocator_unit.sv]
// Top level of the segment placement allocator: controller plus datapath.
// Depends on spa_pkg, spa_ctrl and spa_datapath.
//
// A transaction is accepted when start is high while busy is low, and its single result
// appears for one cycle with done high; the receiver cannot stall it. Allocate walks the
// slot table once through the single read port of the table memory; round robin adds
// the bit-serial remainder and a second table walk. A new transaction can start in the
// cycle done is high.
module segment_placement_allocator_unit #(
  parameter int NUM_SLOTS = spa_pkg::NUM_SLOTS_DEF,
  parameter int SIZE_BITS = spa_pkg::SIZE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 opcode,
  input  logic [spa_pkg::SLOT_W-1:0] slot,
  input  logic [spa_pkg::AMT_W-1:0]  amount,
  input  logic [spa_pkg::MED_W-1:0]  medium_req,
  input  logic [spa_pkg::LAT_W-1:0]  access_lat,
  input  logic [1:0]                 policy,
  input  logic [spa_pkg::SLOT_W-1:0] pref_slot,
  input  logic                       pref_slot_valid,
  input  logic [spa_pkg::MED_W-1:0]  pref_medium,
  input  logic                       pref_medium_valid,
  input  logic                       any_medium_ok,
  output logic                       done,
  output logic [2:0]                 status,
  output logic [spa_pkg::SLOT_W-1:0] chosen_slot,
  output logic [spa_pkg::AMT_W-1:0]  offset,
  output logic [spa_pkg::MED_W-1:0]  chosen_medium
);

  spa_pkg::cmd_t  cmd;
  spa_pkg::stat_t stat;

  spa_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .stat(stat),
    .cmd(cmd),
    .busy(busy)
  );

  spa_datapath #(
    .NUM_SLOTS(NUM_SLOTS),
    .SIZE_BITS(SIZE_BITS)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .stat(stat),
    .opcode(opcode),
    .slot(slot),
    .amount(amount),
    .medium_req(medium_req),
    .access_lat(access_lat),
    .policy(policy),
    .pref_slot(pref_slot),
    .pref_slot_valid(pref_slot_valid),
    .pref_medium(pref_medium),
    .pref_medium_valid(pref_medium_valid),
    .any_medium_ok(any_medium_ok),
    .done(done),
    .status(status),
    .chosen_slot(chosen_slot),
    .offset(offset),
    .chosen_medium(chosen_medium)
  );

  a_done_follows_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("Result strobe without a transaction in progress.");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Accepted transaction did not raise busy.");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != spa_pkg::ST_OK)) |->
      ((chosen_slot == '0) && (offset == '0) && (chosen_medium == '0)))
    else $error("Failed transaction reported a placement.");

endmodule
